// File: src/holonomic_four_wheel_pid_macros.svh
// assertion macros for the checker file
`ifndef HOLONOMIC_FOUR_WHEEL_PID_MACROS_SVH
`define HOLONOMIC_FOUR_WHEEL_PID_MACROS_SVH

// same-cycle implication
`define HFWP_ASSERT_IMP(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("hfwp assertion failed");

// next-cycle implication
`define HFWP_ASSERT_NXT(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("hfwp assertion failed");

`endif

// File: src/hfwp_pkg.sv
// shared types, constants and helpers of the four wheel pid block
package hfwp_pkg;

	localparam int WHEELS = 4;
	localparam int ADDR_W = 5;
	localparam int TGT_W  = 10;
	localparam int ENC_W  = 32;
	localparam int PROD_W = 46;
	localparam int TOT_W  = 48;
	localparam int CMD_MAX = 127;

	localparam logic [11:0] GAIN_P_RST  = 12'd256;
	localparam logic [11:0] GAIN_I_RST  = 12'd128;
	localparam logic [11:0] GAIN_D_RST  = 12'd192;
	localparam logic [15:0] INT_THR_RST = 16'd6;
	localparam logic [6:0]  AXIS_LIM_RST = 7'd115;

	typedef logic signed [TGT_W-1:0] target_t;
	typedef logic signed [ENC_W-1:0] enc_t;
	typedef logic signed [TOT_W-1:0] total_t;

	typedef enum logic [2:0] {
		REG_GAIN_P     = 3'd0,
		REG_GAIN_I     = 3'd1,
		REG_GAIN_D     = 3'd2,
		REG_INT_THR    = 3'd3,
		REG_AXIS_LIMIT = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [11:0] gain_p;
		logic [11:0] gain_i;
		logic [11:0] gain_d;
		logic [15:0] int_thr;
	} cfg_t;

	typedef struct packed {
		logic en_s2;
		logic en_s3;
		logic upd;
		logic en_s4;
		logic en_s5;
	} lane_ctl_t;

	// saturate a 33 bit two's complement value to 32 bits
	function automatic logic [ENC_W-1:0] sat33(input logic [ENC_W:0] v);
		logic [ENC_W-1:0] r;
		if (v[ENC_W] != v[ENC_W-1]) begin
			r = v[ENC_W] ? {1'b1, {(ENC_W-1){1'b0}}} : {1'b0, {(ENC_W-1){1'b1}}};
		end else begin
			r = v[ENC_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: src/holonomic_four_wheel_pid.sv
// top level of the joystick driven four wheel pid controller
//
// Input channel item_valid/item_ready carries three joystick axes and four
// encoder readings; output channel result_valid/result_ready carries four
// saturated motor commands, one result for each input transfer, in order.
// Each axis is capped from above at axis_limit and mixed into x-drive wheel
// targets; four identical lanes then run one pid loop per wheel.
// A result passes the mix, error, state update, products, term sum and
// scale/saturate registers in that order after its input transfer.
// Throughput: one item per cycle unless the receiver stalls; per-wheel error
// sum and last error are read and written in a single stage: items go back to back.
// When the receiver stalls the stages fill in turn and item_ready drops only
// once the output register holds a result and every stage is occupied.
// Reset clears the pipeline, the wheel state and loads the register defaults.
// Registers sit on the apb port at 0x00 gain_p, 0x04 gain_i, 0x08 gain_d,
// 0x0c integrate_threshold, 0x10 axis_limit; write only while idle.
module holonomic_four_wheel_pid #(
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hfwp_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic signed [7:0]             stick_x,
	input  logic signed [7:0]             stick_y,
	input  logic signed [7:0]             stick_z,
	input  logic signed [31:0]            enc_front_left,
	input  logic signed [31:0]            enc_front_right,
	input  logic signed [31:0]            enc_back_right,
	input  logic signed [31:0]            enc_back_left,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic signed [7:0]             drive_front_left,
	output logic signed [7:0]             drive_front_right,
	output logic signed [7:0]             drive_back_right,
	output logic signed [7:0]             drive_back_left
);

	hfwp_pkg::cfg_t cfg_q;
	logic [6:0] axis_limit_q;
	hfwp_pkg::reg_idx_t reg_idx;
	logic wr;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	logic take;
	hfwp_pkg::lane_ctl_t ctl;

	hfwp_pkg::target_t target_s1 [hfwp_pkg::WHEELS];
	hfwp_pkg::enc_t    enc_s1 [hfwp_pkg::WHEELS];
	hfwp_pkg::total_t  total_s5 [hfwp_pkg::WHEELS];

	// configuration port
	assign pready = 1'b1;
	assign reg_idx = hfwp_pkg::reg_idx_t'(paddr[4:2]);
	assign wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p  <= hfwp_pkg::GAIN_P_RST;
			cfg_q.gain_i  <= hfwp_pkg::GAIN_I_RST;
			cfg_q.gain_d  <= hfwp_pkg::GAIN_D_RST;
			cfg_q.int_thr <= hfwp_pkg::INT_THR_RST;
			axis_limit_q  <= hfwp_pkg::AXIS_LIM_RST;
		end else if (wr) begin
			unique case (reg_idx)
				hfwp_pkg::REG_GAIN_P:     cfg_q.gain_p  <= pwdata[11:0];
				hfwp_pkg::REG_GAIN_I:     cfg_q.gain_i  <= pwdata[11:0];
				hfwp_pkg::REG_GAIN_D:     cfg_q.gain_d  <= pwdata[11:0];
				hfwp_pkg::REG_INT_THR:    cfg_q.int_thr <= pwdata[15:0];
				hfwp_pkg::REG_AXIS_LIMIT: axis_limit_q  <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			hfwp_pkg::REG_GAIN_P:     prdata = {20'd0, cfg_q.gain_p};
			hfwp_pkg::REG_GAIN_I:     prdata = {20'd0, cfg_q.gain_i};
			hfwp_pkg::REG_GAIN_D:     prdata = {20'd0, cfg_q.gain_d};
			hfwp_pkg::REG_INT_THR:    prdata = {16'd0, cfg_q.int_thr};
			hfwp_pkg::REG_AXIS_LIMIT: prdata = {25'd0, axis_limit_q};
			default:                  prdata = '0;
		endcase
	end

	// stage occupancy and advance chain
	assign en_s5 = !v_s5 || take;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign item_ready = en_s1;

	assign ctl.en_s2 = en_s2;
	assign ctl.en_s3 = en_s3;
	assign ctl.upd   = en_s3 && v_s2;
	assign ctl.en_s4 = en_s4;
	assign ctl.en_s5 = en_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= item_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	hfwp_mixer u_mixer (
		.clk             (clk),
		.en              (en_s1),
		.axis_limit      (axis_limit_q),
		.stick_x         (stick_x),
		.stick_y         (stick_y),
		.stick_z         (stick_z),
		.enc_front_left  (enc_front_left),
		.enc_front_right (enc_front_right),
		.enc_back_right  (enc_back_right),
		.enc_back_left   (enc_back_left),
		.target_s1       (target_s1),
		.enc_s1          (enc_s1)
	);

	for (genvar w = 0; w < hfwp_pkg::WHEELS; w++) begin : g_lane
		hfwp_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.cfg       (cfg_q),
			.target_s1 (target_s1[w]),
			.enc_s1    (enc_s1[w]),
			.total_s5  (total_s5[w])
		);
	end

	hfwp_merge #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_merge (
		.clk               (clk),
		.arst_n            (arst_n),
		.v_s5              (v_s5),
		.total_s5          (total_s5),
		.result_ready      (result_ready),
		.take              (take),
		.result_valid      (result_valid),
		.drive_front_left  (drive_front_left),
		.drive_front_right (drive_front_right),
		.drive_back_right  (drive_back_right),
		.drive_back_left   (drive_back_left)
	);

endmodule

// File: src/hfwp_mixer.sv
// axis capping and x-drive mixing into four wheel targets, first pipeline stage
module hfwp_mixer (
	input  logic                    clk,
	input  logic                    en,
	input  logic [6:0]              axis_limit,
	input  logic signed [7:0]       stick_x,
	input  logic signed [7:0]       stick_y,
	input  logic signed [7:0]       stick_z,
	input  logic signed [31:0]      enc_front_left,
	input  logic signed [31:0]      enc_front_right,
	input  logic signed [31:0]      enc_back_right,
	input  logic signed [31:0]      enc_back_left,
	output hfwp_pkg::target_t       target_s1 [hfwp_pkg::WHEELS],
	output hfwp_pkg::enc_t          enc_s1 [hfwp_pkg::WHEELS]
);

	logic signed [7:0] lim, cx, cy, cz;
	hfwp_pkg::target_t ex, ey, ez;
	hfwp_pkg::target_t tgt [hfwp_pkg::WHEELS];

	assign lim = $signed({1'b0, axis_limit});
	assign cx = (stick_x > lim) ? lim : stick_x;
	assign cy = (stick_y > lim) ? lim : stick_y;
	assign cz = (stick_z > lim) ? lim : stick_z;

	assign ex = {{2{cx[7]}}, cx};
	assign ey = {{2{cy[7]}}, cy};
	assign ez = {{2{cz[7]}}, cz};

	assign tgt[0] = ey + ex + ez;
	assign tgt[1] = ex + ez - ey;
	assign tgt[2] = ez - ey - ex;
	assign tgt[3] = ey - ex + ez;

	always_ff @(posedge clk) begin
		if (en) begin
			target_s1 <= tgt;
			enc_s1[0] <= enc_front_left;
			enc_s1[1] <= enc_front_right;
			enc_s1[2] <= enc_back_right;
			enc_s1[3] <= enc_back_left;
		end
	end

endmodule

// File: src/hfwp_lane.sv
// one wheel's pid pipeline: error, state update, products and term sum
module hfwp_lane (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hfwp_pkg::lane_ctl_t   ctl,
	input  hfwp_pkg::cfg_t        cfg,
	input  hfwp_pkg::target_t     target_s1,
	input  hfwp_pkg::enc_t        enc_s1,
	output hfwp_pkg::total_t      total_s5
);

	logic [32:0] raw_err;
	logic signed [31:0] err_c;
	logic signed [31:0] err_s2, err_s3, sum_s3;
	logic signed [32:0] diff_s3;
	logic signed [31:0] prev_q, esum_q;
	logic signed [32:0] err_x, thr_x, diff_c;
	logic [32:0] sum_raw;
	logic signed [31:0] sum_c;
	logic signed [45:0] p_c, d_c, i_c;
	logic signed [45:0] p_s4, d_s4, i_s4;
	hfwp_pkg::total_t total_c;

	assign raw_err = {{23{target_s1[9]}}, target_s1} - {enc_s1[31], enc_s1};
	assign err_c = hfwp_pkg::sat33(raw_err);

	assign err_x = {err_s2[31], err_s2};
	assign thr_x = $signed({17'd0, cfg.int_thr});
	assign sum_raw = {esum_q[31], esum_q} + {err_s2[31], err_s2};
	assign sum_c = (err_x > thr_x) ? 32'sd0 : hfwp_pkg::sat33(sum_raw);
	assign diff_c = {prev_q[31], prev_q} - err_x;

	assign p_c = err_s3 * $signed({1'b0, cfg.gain_p});
	assign d_c = diff_s3 * $signed({1'b0, cfg.gain_d});
	assign i_c = sum_s3 * $signed({1'b0, cfg.gain_i});

	assign total_c = {{2{p_s4[45]}}, p_s4} + {{2{d_s4[45]}}, d_s4} + {{2{i_s4[45]}}, i_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			esum_q <= '0;
		end else if (ctl.upd) begin
			prev_q <= err_s2;
			esum_q <= sum_c;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			err_s2 <= err_c;
		end
		if (ctl.en_s3) begin
			err_s3  <= err_s2;
			diff_s3 <= diff_c;
			sum_s3  <= sum_c;
		end
		if (ctl.en_s4) begin
			p_s4 <= p_c;
			d_s4 <= d_c;
			i_s4 <= i_c;
		end
		if (ctl.en_s5) begin
			total_s5 <= total_c;
		end
	end

endmodule

// File: src/hfwp_merge.sv
// scales and saturates the four lane totals into the result register
module hfwp_merge #(
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               v_s5,
	input  hfwp_pkg::total_t   total_s5 [hfwp_pkg::WHEELS],
	input  logic               result_ready,
	output logic               take,
	output logic               result_valid,
	output logic signed [7:0]  drive_front_left,
	output logic signed [7:0]  drive_front_right,
	output logic signed [7:0]  drive_back_right,
	output logic signed [7:0]  drive_back_left
);

	localparam int TotW = hfwp_pkg::TOT_W;
	localparam logic [TotW-1:0] RoundBias = (TotW'(1) << GAIN_FRAC_BITS) - TotW'(1);
	localparam logic signed [TotW-1:0] CmdHi = TotW'(hfwp_pkg::CMD_MAX);
	localparam logic signed [TotW-1:0] CmdLo = -CmdHi;

	logic signed [7:0] cmd_c [hfwp_pkg::WHEELS];

	always_comb begin
		for (int w = 0; w < hfwp_pkg::WHEELS; w++) begin
			logic signed [TotW-1:0] adj;
			logic signed [TotW-1:0] q;
			adj = total_s5[w] + (total_s5[w][TotW-1] ? RoundBias : '0);
			q = adj >>> GAIN_FRAC_BITS;
			if (q > CmdHi) begin
				cmd_c[w] = CmdHi[7:0];
			end else if (q < CmdLo) begin
				cmd_c[w] = CmdLo[7:0];
			end else begin
				cmd_c[w] = q[7:0];
			end
		end
	end

	assign take = !result_valid || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (take) begin
			result_valid <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (take && v_s5) begin
			drive_front_left  <= cmd_c[0];
			drive_front_right <= cmd_c[1];
			drive_back_right  <= cmd_c[2];
			drive_back_left   <= cmd_c[3];
		end
	end

endmodule

// File: src/hfwp_checker.sv
// port level checker for the four wheel pid block and its bind
`include "holonomic_four_wheel_pid_macros.svh"

module hfwp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          psel,
	input logic                          penable,
	input logic                          pwrite,
	input logic [hfwp_pkg::ADDR_W-1:0]   paddr,
	input logic [31:0]                   pwdata,
	input logic [31:0]                   prdata,
	input logic                          pready,
	input logic                          item_valid,
	input logic                          item_ready,
	input logic                          result_valid,
	input logic                          result_ready,
	input logic signed [7:0]             drive_front_left,
	input logic signed [7:0]             drive_front_right,
	input logic signed [7:0]             drive_back_right,
	input logic signed [7:0]             drive_back_left
);

	// a stalled result keeps its value
	`HFWP_ASSERT_NXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(drive_front_left) && $stable(drive_front_right) && $stable(drive_back_right) && $stable(drive_back_left))

	// commands never reach the most negative code
	`HFWP_ASSERT_IMP(a_drive_range, clk, arst_n, result_valid, drive_front_left != 8'sh80 && drive_front_right != 8'sh80 && drive_back_right != 8'sh80 && drive_back_left != 8'sh80)

	// input backpressure only comes from a blocked output
	`HFWP_ASSERT_IMP(a_stall_source, clk, arst_n, !item_ready, result_valid && !result_ready)

	// gain_p reads back what was written, masked to its width
	`HFWP_ASSERT_IMP(a_gain_p_readback, clk, arst_n, (psel && penable && pwrite && pready && paddr == 5'd0) ##1 (psel && !pwrite && paddr == 5'd0), prdata[11:0] == $past(pwdata[11:0]) && prdata[31:12] == 20'd0)

endmodule

bind holonomic_four_wheel_pid hfwp_checker u_hfwp_checker (.*);

// File: bench/testbench.sv
// self-checking testbench of the four wheel pid controller, driven over valid/ready and apb
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     PERIOD       = 10;
	localparam int     RESET_CYCLES = 7;
	localparam int     FRAC_BITS    = 8;
	localparam int     N_PHASES     = 8;
	localparam int     PHASE_ITEMS  = 180;
	localparam int     DRAIN_PAD    = 20;
	localparam int     LIMIT_CYCLES = 400000;
	localparam longint S32_MAX      = 64'sh7FFF_FFFF;
	localparam longint S32_MIN      = -64'sh8000_0000;

	typedef struct packed {
		logic signed [7:0]  x;
		logic signed [7:0]  y;
		logic signed [7:0]  z;
		logic signed [31:0] enc_fl;
		logic signed [31:0] enc_fr;
		logic signed [31:0] enc_br;
		logic signed [31:0] enc_bl;
	} stick_sample_t;

	typedef struct packed {
		logic signed [7:0] fl;
		logic signed [7:0] fr;
		logic signed [7:0] br;
		logic signed [7:0] bl;
	} drive_cmd_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [hfwp_pkg::ADDR_W-1:0]   paddr = '0;
	logic [31:0]                   pwdata = '0;
	logic [31:0]                   prdata;
	logic                          pready;
	logic                          item_valid = 1'b0;
	logic                          item_ready;
	logic signed [7:0]             stick_x = '0;
	logic signed [7:0]             stick_y = '0;
	logic signed [7:0]             stick_z = '0;
	logic signed [31:0]            enc_front_left = '0;
	logic signed [31:0]            enc_front_right = '0;
	logic signed [31:0]            enc_back_right = '0;
	logic signed [31:0]            enc_back_left = '0;
	logic                          result_valid;
	logic                          result_ready = 1'b0;
	logic signed [7:0]             drive_front_left;
	logic signed [7:0]             drive_front_right;
	logic signed [7:0]             drive_back_right;
	logic signed [7:0]             drive_back_left;

	// shadow copy of the registers and the per-wheel loop state
	logic [11:0] kp = hfwp_pkg::GAIN_P_RST;
	logic [11:0] ki = hfwp_pkg::GAIN_I_RST;
	logic [11:0] kd = hfwp_pkg::GAIN_D_RST;
	logic [15:0] thr = hfwp_pkg::INT_THR_RST;
	logic [6:0]  lim = hfwp_pkg::AXIS_LIM_RST;
	int          last_error [hfwp_pkg::WHEELS] = '{default: 0};
	int          error_sum [hfwp_pkg::WHEELS] = '{default: 0};

	stick_sample_t pending_samples [$];
	drive_cmd_t    expected_drive [$];
	stick_sample_t held_sample;
	drive_cmd_t    want_cmd;
	drive_cmd_t    got_cmd;
	string         wheel_name [hfwp_pkg::WHEELS] =
		'{"back left", "back right", "front right", "front left"};

	int idle_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int samples_sent = 0;
	int results_checked = 0;
	int config_count = 0;
	int cycles = 0;

	holonomic_four_wheel_pid dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.stick_x(stick_x),
		.stick_y(stick_y),
		.stick_z(stick_z),
		.enc_front_left(enc_front_left),
		.enc_front_right(enc_front_right),
		.enc_back_right(enc_back_right),
		.enc_back_left(enc_back_left),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.drive_front_left(drive_front_left),
		.drive_front_right(drive_front_right),
		.drive_back_right(drive_back_right),
		.drive_back_left(drive_back_left)
	);

	always #(PERIOD / 2) clk = ~clk;

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic longint cap_axis(input longint a);
		if (a > longint'(lim)) return longint'(lim);
		return a;
	endfunction

	// mixes the sticks, runs the four wheel loops and advances their state
	function automatic drive_cmd_t pid_update(input stick_sample_t s);
		longint     x, y, z, err, diff_term, sum;
		longint     tgt [hfwp_pkg::WHEELS];
		longint     enc [hfwp_pkg::WHEELS];
		longint     cmd [hfwp_pkg::WHEELS];
		drive_cmd_t r;
		x = cap_axis(longint'($signed(s.x)));
		y = cap_axis(longint'($signed(s.y)));
		z = cap_axis(longint'($signed(s.z)));
		tgt[0] = y + x + z;
		tgt[1] = -y + x + z;
		tgt[2] = -y - x + z;
		tgt[3] = y - x + z;
		enc[0] = longint'($signed(s.enc_fl));
		enc[1] = longint'($signed(s.enc_fr));
		enc[2] = longint'($signed(s.enc_br));
		enc[3] = longint'($signed(s.enc_bl));
		for (int w = 0; w < hfwp_pkg::WHEELS; w++) begin
			err = clamp(tgt[w] - enc[w], S32_MIN, S32_MAX);
			diff_term = (longint'(last_error[w]) - err) * longint'(kd);
			if (err > longint'(thr)) begin
				sum = 0;
			end else begin
				sum = clamp(longint'(error_sum[w]) + err, S32_MIN, S32_MAX);
			end
			error_sum[w] = int'(sum);
			last_error[w] = int'(err);
			cmd[w] = clamp((err * longint'(kp) + diff_term + sum * longint'(ki))
				/ (longint'(1) <<< FRAC_BITS), -hfwp_pkg::CMD_MAX, hfwp_pkg::CMD_MAX);
		end
		r.fl = 8'(cmd[0]);
		r.fr = 8'(cmd[1]);
		r.br = 8'(cmd[2]);
		r.bl = 8'(cmd[3]);
		return r;
	endfunction

	function automatic logic signed [7:0] random_axis();
		case ($urandom_range(9))
			0: return 8'sh80;
			1: return 8'sh7F;
			default: return 8'($urandom);
		endcase
	endfunction

	// half the time near the wheel target so the loop stays out of saturation
	function automatic logic signed [31:0] random_encoder(input int target);
		int sel;
		sel = $urandom_range(99);
		if (sel < 50) return 32'(target + int'($urandom_range(16)) - 8);
		if (sel < 75) return 32'(int'($urandom_range(1000)) - 500);
		if (sel < 85) return sel[0] ? 32'h7FFF_FFFF - $urandom_range(400)
			: 32'h8000_0000 + $urandom_range(400);
		return $urandom;
	endfunction

	function automatic stick_sample_t random_sample();
		stick_sample_t s;
		int            fwd, side, rot;
		s.x = random_axis();
		s.y = random_axis();
		s.z = random_axis();
		fwd = s.y;
		side = s.x;
		rot = s.z;
		s.enc_fl = random_encoder(fwd + side + rot);
		s.enc_fr = random_encoder(-fwd + side + rot);
		s.enc_br = random_encoder(-fwd - side + rot);
		s.enc_bl = random_encoder(fwd - side + rot);
		return s;
	endfunction

	task automatic report_error(input string msg);
		mismatches++;
		if (mismatches <= 10) $display("mismatch: %s", msg);
	endtask

	task automatic add_sample(input logic signed [7:0] x, y, z,
		input logic signed [31:0] fl, fr, br, bl);
		pending_samples.push_back('{x, y, z, fl, fr, br, bl});
	endtask

	task automatic apb_write(input int idx, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= hfwp_pkg::ADDR_W'(idx * 4);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			hfwp_pkg::REG_GAIN_P:     kp = data[11:0];
			hfwp_pkg::REG_GAIN_I:     ki = data[11:0];
			hfwp_pkg::REG_GAIN_D:     kd = data[11:0];
			hfwp_pkg::REG_INT_THR:    thr = data[15:0];
			hfwp_pkg::REG_AXIS_LIMIT: lim = data[6:0];
			default: ;
		endcase
	endtask

	task automatic apb_read_check(input int idx, input logic [31:0] want);
		logic [31:0] got;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= hfwp_pkg::ADDR_W'(idx * 4);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== want)
			report_error($sformatf("register %0d read: expected 0x%08h, got 0x%08h",
				idx, want, got));
	endtask

	task automatic check_registers();
		apb_read_check(hfwp_pkg::REG_GAIN_P, 32'(kp));
		apb_read_check(hfwp_pkg::REG_GAIN_I, 32'(ki));
		apb_read_check(hfwp_pkg::REG_GAIN_D, 32'(kd));
		apb_read_check(hfwp_pkg::REG_INT_THR, 32'(thr));
		apb_read_check(hfwp_pkg::REG_AXIS_LIMIT, 32'(lim));
	endtask

	task automatic apply_config(input logic [31:0] p, i, d, t, l);
		apb_write(hfwp_pkg::REG_GAIN_P, p);
		apb_write(hfwp_pkg::REG_GAIN_I, i);
		apb_write(hfwp_pkg::REG_GAIN_D, d);
		apb_write(hfwp_pkg::REG_INT_THR, t);
		apb_write(hfwp_pkg::REG_AXIS_LIMIT, l);
		// unmapped addresses must leave everything alone
		for (int a = hfwp_pkg::REG_AXIS_LIMIT + 1; a < (1 << (hfwp_pkg::ADDR_W - 2)); a++)
			apb_write(a, $urandom);
		check_registers();
		config_count++;
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_samples.size() != 0 || item_valid || expected_drive.size() != 0);
	endtask

	// input driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready) begin
				expected_drive.push_back(pid_update(held_sample));
				samples_sent++;
			end
			if (!item_valid || item_ready) begin
				if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
					held_sample = pending_samples.pop_front();
					item_valid <= 1'b1;
					stick_x <= held_sample.x;
					stick_y <= held_sample.y;
					stick_z <= held_sample.z;
					enc_front_left <= held_sample.enc_fl;
					enc_front_right <= held_sample.enc_fr;
					enc_back_right <= held_sample.enc_br;
					enc_back_left <= held_sample.enc_bl;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= stall_pct);
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			results_checked++;
			if (expected_drive.size() == 0) begin
				report_error($sformatf("result %0d transfer with nothing expected",
					results_checked));
			end else begin
				want_cmd = expected_drive.pop_front();
				got_cmd = {drive_front_left, drive_front_right, drive_back_right,
					drive_back_left};
				for (int w = 0; w < hfwp_pkg::WHEELS; w++) begin
					if (got_cmd[8*w +: 8] !== want_cmd[8*w +: 8])
						report_error($sformatf("result %0d %s: expected %0d, got %0d",
							results_checked, wheel_name[w], $signed(want_cmd[8*w +: 8]),
							$signed(got_cmd[8*w +: 8])));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		check_registers();
		@(negedge clk);

		// directed samples on the reset settings
		add_sample(0, 0, 0, 0, 0, 0, 0);
		add_sample(127, 127, 127, 0, 0, 0, 0);
		add_sample(-128, -128, -128, 0, 0, 0, 0);
		add_sample(127, -128, 0, 0, 0, 0, 0);
		add_sample(115, 116, -127, 0, 0, 0, 0);
		// error overflow in both directions, then the sum pinned at its minimum
		add_sample(127, 127, 127, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh8000_0000);
		add_sample(-128, -128, -128, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF);
		add_sample(-128, -128, -128, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF);
		add_sample(-128, -128, -128, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF);
		// error just under, at and just over the integrate threshold
		add_sample(0, 0, 0, -1, -1, -1, -1);
		add_sample(0, 0, 0, -6, -6, -6, -6);
		add_sample(0, 0, 0, -7, -7, -7, -7);
		add_sample(0, 0, 0, 5, 5, 5, 5);
		add_sample(8'sh55, 8'shAA, 8'sh55, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
			32'shAAAA_AAAA);
		add_sample(8'shAA, 8'sh55, 8'shAA, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
			32'sh5555_5555);
		add_sample(0, 0, 0, 1000, -1000, 1000, -1000);
		add_sample(0, 0, 0, -1000, 1000, -1000, 1000);
		add_sample(10, 20, -5, 30, -20, 0, 7);
		add_sample(10, 20, -5, 26, -14, -12, 2);
		add_sample(-3, 4, 1, 2, -6, 0, 8);
		add_sample(-3, 4, 1, 1, -5, 1, 7);
		wait_drained();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: apply_config(0, 0, 0, 0, 0);
				1: apply_config(4095, 4095, 4095, 65535, 127);
				2: apply_config(64, 8, 32, 40, 90);
				4: apply_config(32'hFFFF_F100, 32'hABCD_E080, 32'h1234_50C0, 32'hFFFF_0006,
					32'hFFFF_FFF3);
				5: apply_config(4095, 0, 4095, 0, 127);
				6: apply_config(16, 1, 8, 1000, 60);
				default: apply_config($urandom, $urandom, $urandom, $urandom, $urandom);
			endcase
			@(negedge clk);
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 72; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 72; end
				default: begin idle_pct = 19; stall_pct = 19; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) pending_samples.push_back(random_sample());
			wait_drained();
		end

		repeat (DRAIN_PAD) @(negedge clk);
		if (expected_drive.size() != 0)
			report_error($sformatf("%0d results never arrived", expected_drive.size()));
		$display("summary: %0d joystick samples under %0d register settings, %0d results",
			samples_sent, config_count + 1, results_checked);
		$display("summary: %0d mismatches in %0d cycles", mismatches, cycles);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+src
src/hfwp_pkg.sv
src/hfwp_mixer.sv
src/hfwp_lane.sv
src/hfwp_merge.sv
src/holonomic_four_wheel_pid.sv
src/hfwp_checker.sv
bench/testbench.sv
